[rtl/lcb_pkg.sv]
// ----------------------------------------------------------------------------
// lcb_pkg
// shared sizes, codes and handshake structs of the surface cache directory
// ----------------------------------------------------------------------------
package lcb_pkg;

    localparam int SLOTS      = 128;
    localparam int KEY_BITS   = 64;
    localparam int KEY_PORT_W = 64;
    localparam int IDX_W      = $clog2(SLOTS);
    localparam int CNT_W      = $clog2(SLOTS + 1);
    localparam int STAMP_W    = 40;
    localparam int SIDE_W     = 13;
    localparam int AREA_W     = 2 * SIDE_W;
    localparam int PIX_W      = 19;
    localparam int BPP_SHIFT  = 2;
    localparam int BYTES_W    = PIX_W + BPP_SHIFT;
    localparam int TOTAL_W    = 27;
    localparam int CFG_W      = 27;
    localparam int CFG_IDX_W  = 2;
    localparam int SLOT_OUT_W = 7;
    localparam int EVICT_W    = 8;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

    localparam logic [CFG_IDX_W-1:0] CFG_BUDGET = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PIXEL  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SIDE   = 2'd2;

    localparam logic [TOTAL_W-1:0] BUDGET_RST = TOTAL_W'(16 * 1024 * 1024);
    localparam logic [PIX_W-1:0]   PIXEL_RST  = PIX_W'(262144);
    localparam logic [SIDE_W-1:0]  SIDE_RST   = SIDE_W'(4096);

    typedef enum logic [1:0] {
        ST_REJECT = 2'd0,
        ST_HIT    = 2'd1,
        ST_INSERT = 2'd2,
        ST_FLUSH  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        SCAN_HIT   = 2'd0,
        SCAN_LRU   = 2'd1,
        SCAN_FREE  = 2'd2,
        SCAN_COUNT = 2'd3
    } scan_mode_t;

    typedef struct packed {
        logic       go;
        scan_mode_t mode;
    } scan_req_t;

    typedef struct packed {
        logic               done;
        logic               found;
        logic [IDX_W-1:0]   idx;
        logic [BYTES_W-1:0] bytes;
        logic [CNT_W-1:0]   count;
    } scan_rsp_t;

endpackage

[rtl/lru_cache_with_byte_budget.sv]
// ----------------------------------------------------------------------------
// lru_cache_with_byte_budget
// fully associative surface cache directory with lru eviction under a byte
// budget; a sequencer drives one shared slot scanner over the slot rams
// ----------------------------------------------------------------------------
//  channel   handshake           payload
//  request   start / busy        func key width height drawable store_ok
//  result    done (strobe)       status slot evicted_count bytes_in_use
//  config    cfg_we              cfg_addr cfg_wdata
//
//  every slot scan walks all SLOTS slots (one slot ram read per cycle)
//  reject on size needs no scan; lookup runs one hit scan
//  miss: one more scan per budget eviction, one for the free slot search and
//  one more when no slot is free; flush: one count scan
//  reset clears the valid bits at once, no clearing pass
//  a result beat is shown for one cycle and cannot be stalled
// ----------------------------------------------------------------------------
module lru_cache_with_byte_budget (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic                            func,
    input  logic [lcb_pkg::KEY_PORT_W-1:0]  key,
    input  logic [lcb_pkg::SIDE_W-1:0]      width,
    input  logic [lcb_pkg::SIDE_W-1:0]      height,
    input  logic                            drawable,
    input  logic                            store_ok,
    output logic                            done,
    output logic [1:0]                      status,
    output logic [lcb_pkg::SLOT_OUT_W-1:0]  slot,
    output logic [lcb_pkg::EVICT_W-1:0]     evicted_count,
    output logic [lcb_pkg::TOTAL_W-1:0]     bytes_in_use,
    input  logic                            cfg_we,
    input  logic [lcb_pkg::CFG_IDX_W-1:0]   cfg_addr,
    input  logic [lcb_pkg::CFG_W-1:0]       cfg_wdata
);
    import lcb_pkg::*;

    typedef enum logic [9:0] {
        S_IDLE    = 10'b00_0000_0001,
        S_MUL     = 10'b00_0000_0010,
        S_CHECK   = 10'b00_0000_0100,
        S_HIT     = 10'b00_0000_1000,
        S_BUDGET  = 10'b00_0001_0000,
        S_EVICT   = 10'b00_0010_0000,
        S_FREE    = 10'b00_0100_0000,
        S_REPLACE = 10'b00_1000_0000,
        S_INSERT  = 10'b01_0000_0000,
        S_FLUSH   = 10'b10_0000_0000
    } state_t;

    state_t state_reg, state_next;

    logic [KEY_BITS-1:0] key_reg;
    logic [SIDE_W-1:0]   w_reg;
    logic [SIDE_W-1:0]   h_reg;
    logic                draw_reg;
    logic                store_reg;
    logic [AREA_W-1:0]   area_reg;

    logic [TOTAL_W-1:0]  budget_reg;
    logic [PIX_W-1:0]    pixel_reg;
    logic [SIDE_W-1:0]   side_reg;

    logic [SLOTS-1:0]    valid_reg, valid_next;
    logic [TOTAL_W-1:0]  total_reg, total_next;
    logic [STAMP_W-1:0]  clock_reg, clock_next;
    logic [CNT_W-1:0]    ev_reg, ev_next;
    logic [IDX_W-1:0]    ins_reg, ins_next;

    logic                done_reg, done_next;
    status_t             status_reg, status_next;
    logic [IDX_W-1:0]    slot_reg, slot_next;
    logic [CNT_W-1:0]    evout_reg, evout_next;

    scan_req_t           scan_req;
    scan_rsp_t           scan_rsp;
    logic [IDX_W-1:0]    rd_addr;
    logic [KEY_BITS-1:0] key_rd;
    logic [STAMP_W-1:0]  stamp_rd;
    logic [BYTES_W-1:0]  bytes_rd;

    logic                key_we;
    logic                bytes_we;
    logic                stamp_we;
    logic [IDX_W-1:0]    waddr;
    logic [STAMP_W-1:0]  clock_plus;
    logic [BYTES_W-1:0]  entry_bytes;
    logic [TOTAL_W-1:0]  entry_total;
    logic [TOTAL_W-1:0]  victim_total;
    logic [TOTAL_W:0]    need_sum;
    logic                over_budget;
    logic                reject;
    logic                accept;

    logic [IDX_W+SLOT_OUT_W-1:0] slot_wide;
    logic [CNT_W+EVICT_W-1:0]    evict_wide;

    assign accept       = start && (state_reg == S_IDLE);
    assign clock_plus   = clock_reg + STAMP_W'(1);
    assign entry_bytes  = {area_reg[PIX_W-1:0], {BPP_SHIFT{1'b0}}};
    assign entry_total  = {{(TOTAL_W-BYTES_W){1'b0}}, entry_bytes};
    assign victim_total = {{(TOTAL_W-BYTES_W){1'b0}}, scan_rsp.bytes};
    assign need_sum     = {1'b0, total_reg} + {1'b0, entry_total};
    assign over_budget  = need_sum > {1'b0, budget_reg};
    assign reject       = !draw_reg || (w_reg == '0) || (h_reg == '0) ||
                          (w_reg > side_reg) || (h_reg > side_reg) ||
                          (area_reg > {{(AREA_W-PIX_W){1'b0}}, pixel_reg});

    always_comb
    begin
        state_next    = state_reg;
        valid_next    = valid_reg;
        total_next    = total_reg;
        clock_next    = clock_reg;
        ev_next       = ev_reg;
        ins_next      = ins_reg;
        done_next     = 1'b0;
        status_next   = status_reg;
        slot_next     = slot_reg;
        evout_next    = evout_reg;
        scan_req.go   = 1'b0;
        scan_req.mode = SCAN_HIT;
        key_we        = 1'b0;
        bytes_we      = 1'b0;
        stamp_we      = 1'b0;
        waddr         = ins_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    ev_next = '0;
                    if (func)
                    begin
                        scan_req.go   = 1'b1;
                        scan_req.mode = SCAN_COUNT;
                        state_next    = S_FLUSH;
                    end
                    else
                    begin
                        state_next = S_MUL;
                    end
                end
            end
            S_MUL:
            begin
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (reject)
                begin
                    done_next   = 1'b1;
                    status_next = ST_REJECT;
                    slot_next   = '0;
                    evout_next  = '0;
                    state_next  = S_IDLE;
                end
                else
                begin
                    scan_req.go   = 1'b1;
                    scan_req.mode = SCAN_HIT;
                    state_next    = S_HIT;
                end
            end
            S_HIT:
            begin
                if (scan_rsp.done)
                begin
                    if (scan_rsp.found)
                    begin
                        clock_next  = clock_plus;
                        stamp_we    = 1'b1;
                        waddr       = scan_rsp.idx;
                        done_next   = 1'b1;
                        status_next = ST_HIT;
                        slot_next   = scan_rsp.idx;
                        evout_next  = '0;
                        state_next  = S_IDLE;
                    end
                    else if (!store_reg)
                    begin
                        done_next   = 1'b1;
                        status_next = ST_REJECT;
                        slot_next   = '0;
                        evout_next  = '0;
                        state_next  = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_BUDGET;
                    end
                end
            end
            S_BUDGET:
            begin
                scan_req.go = 1'b1;
                if (over_budget)
                begin
                    scan_req.mode = SCAN_LRU;
                    state_next    = S_EVICT;
                end
                else
                begin
                    scan_req.mode = SCAN_FREE;
                    state_next    = S_FREE;
                end
            end
            S_EVICT:
            begin
                if (scan_rsp.done)
                begin
                    if (scan_rsp.found)
                    begin
                        valid_next[scan_rsp.idx] = 1'b0;
                        total_next = total_reg - victim_total;
                        ev_next    = ev_reg + CNT_W'(1);
                        state_next = S_BUDGET;
                    end
                    else
                    begin
                        scan_req.go   = 1'b1;
                        scan_req.mode = SCAN_FREE;
                        state_next    = S_FREE;
                    end
                end
            end
            S_FREE:
            begin
                if (scan_rsp.done)
                begin
                    if (scan_rsp.found)
                    begin
                        ins_next   = scan_rsp.idx;
                        state_next = S_INSERT;
                    end
                    else
                    begin
                        scan_req.go   = 1'b1;
                        scan_req.mode = SCAN_LRU;
                        state_next    = S_REPLACE;
                    end
                end
            end
            S_REPLACE:
            begin
                if (scan_rsp.done)
                begin
                    if (scan_rsp.found)
                    begin
                        valid_next[scan_rsp.idx] = 1'b0;
                        total_next = total_reg - victim_total;
                    end
                    ev_next    = ev_reg + CNT_W'(1);
                    ins_next   = scan_rsp.idx;
                    state_next = S_INSERT;
                end
            end
            S_INSERT:
            begin
                valid_next[ins_reg] = 1'b1;
                key_we      = 1'b1;
                bytes_we    = 1'b1;
                stamp_we    = 1'b1;
                total_next  = total_reg + entry_total;
                clock_next  = clock_plus;
                done_next   = 1'b1;
                status_next = ST_INSERT;
                slot_next   = ins_reg;
                evout_next  = ev_reg;
                state_next  = S_IDLE;
            end
            S_FLUSH:
            begin
                if (scan_rsp.done)
                begin
                    valid_next  = '0;
                    total_next  = '0;
                    clock_next  = '0;
                    done_next   = 1'b1;
                    status_next = ST_FLUSH;
                    slot_next   = '0;
                    evout_next  = scan_rsp.count;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            valid_reg  <= '0;
            total_reg  <= '0;
            clock_reg  <= '0;
            ev_reg     <= '0;
            ins_reg    <= '0;
            done_reg   <= 1'b0;
            status_reg <= ST_REJECT;
            slot_reg   <= '0;
            evout_reg  <= '0;
            budget_reg <= BUDGET_RST;
            pixel_reg  <= PIXEL_RST;
            side_reg   <= SIDE_RST;
        end
        else
        begin
            state_reg  <= state_next;
            valid_reg  <= valid_next;
            total_reg  <= total_next;
            clock_reg  <= clock_next;
            ev_reg     <= ev_next;
            ins_reg    <= ins_next;
            done_reg   <= done_next;
            status_reg <= status_next;
            slot_reg   <= slot_next;
            evout_reg  <= evout_next;
            if (cfg_we)
            begin
                case (cfg_addr)
                    CFG_BUDGET: budget_reg <= cfg_wdata[TOTAL_W-1:0];
                    CFG_PIXEL:  pixel_reg  <= cfg_wdata[PIX_W-1:0];
                    CFG_SIDE:   side_reg   <= cfg_wdata[SIDE_W-1:0];
                    default:    ;
                endcase
            end
        end
    end

    // request beat and area register
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            key_reg   <= key[KEY_BITS-1:0];
            w_reg     <= width;
            h_reg     <= height;
            draw_reg  <= drawable;
            store_reg <= store_ok;
        end
        if (state_reg == S_MUL)
        begin
            area_reg <= AREA_W'(w_reg) * AREA_W'(h_reg);
        end
    end

    lcb_scan u_scan (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (scan_req),
        .key      (key_reg),
        .valid    (valid_reg),
        .key_rd   (key_rd),
        .stamp_rd (stamp_rd),
        .bytes_rd (bytes_rd),
        .rd_addr  (rd_addr),
        .rsp      (scan_rsp)
    );

    lcb_ram #(
        .WIDTH (KEY_BITS),
        .DEPTH (SLOTS)
    ) u_key_ram (
        .clk   (clk),
        .we    (key_we),
        .waddr (waddr),
        .wdata (key_reg),
        .raddr (rd_addr),
        .rdata (key_rd)
    );

    lcb_ram #(
        .WIDTH (BYTES_W),
        .DEPTH (SLOTS)
    ) u_bytes_ram (
        .clk   (clk),
        .we    (bytes_we),
        .waddr (waddr),
        .wdata (entry_bytes),
        .raddr (rd_addr),
        .rdata (bytes_rd)
    );

    lcb_ram #(
        .WIDTH (STAMP_W),
        .DEPTH (SLOTS)
    ) u_stamp_ram (
        .clk   (clk),
        .we    (stamp_we),
        .waddr (waddr),
        .wdata (clock_plus),
        .raddr (rd_addr),
        .rdata (stamp_rd)
    );

    assign slot_wide  = {{SLOT_OUT_W{1'b0}}, slot_reg};
    assign evict_wide = {{EVICT_W{1'b0}}, evout_reg};

    assign busy          = (state_reg != S_IDLE);
    assign done          = done_reg;
    assign status        = status_reg;
    assign slot          = slot_wide[SLOT_OUT_W-1:0];
    assign evicted_count = evict_wide[EVICT_W-1:0];
    assign bytes_in_use  = total_reg;

endmodule

[rtl/lcb_ram.sv]
// ----------------------------------------------------------------------------
// lcb_ram
// generic single write port ram with one registered read port
// ----------------------------------------------------------------------------
module lcb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/lcb_scan.sv]
// ----------------------------------------------------------------------------
// lcb_scan
// shared slot scanner: walks every slot once, one per cycle, and runs a
// single compare unit for key match, oldest stamp, first free or valid count
// ----------------------------------------------------------------------------
module lcb_scan (
    input  logic                          clk,
    input  logic                          rst_n,
    input  lcb_pkg::scan_req_t            req,
    input  logic [lcb_pkg::KEY_BITS-1:0]  key,
    input  logic [lcb_pkg::SLOTS-1:0]     valid,
    input  logic [lcb_pkg::KEY_BITS-1:0]  key_rd,
    input  logic [lcb_pkg::STAMP_W-1:0]   stamp_rd,
    input  logic [lcb_pkg::BYTES_W-1:0]   bytes_rd,
    output logic [lcb_pkg::IDX_W-1:0]     rd_addr,
    output lcb_pkg::scan_rsp_t            rsp
);
    import lcb_pkg::*;

    logic               run_reg;
    scan_mode_t         mode_reg;
    logic [IDX_W-1:0]   addr_reg;
    logic               pipe_reg;
    logic [IDX_W-1:0]   pidx_reg;
    logic               done_reg;
    logic               found_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic [STAMP_W-1:0] stamp_reg;
    logic [BYTES_W-1:0] bytes_reg;
    logic [CNT_W-1:0]   count_reg;

    logic slot_on;
    logic take;
    logic count_inc;

    always_comb
    begin
        slot_on   = valid[pidx_reg];
        count_inc = 1'b0;
        case (mode_reg)
            SCAN_HIT:   take = slot_on && (key_rd == key) && !found_reg;
            SCAN_LRU:   take = slot_on && (!found_reg || (stamp_rd < stamp_reg));
            SCAN_FREE:  take = !slot_on && !found_reg;
            SCAN_COUNT:
            begin
                take      = 1'b0;
                count_inc = slot_on;
            end
            default:    take = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg   <= 1'b0;
            mode_reg  <= SCAN_HIT;
            addr_reg  <= '0;
            pipe_reg  <= 1'b0;
            pidx_reg  <= '0;
            done_reg  <= 1'b0;
            found_reg <= 1'b0;
            idx_reg   <= '0;
            stamp_reg <= '0;
            bytes_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            pipe_reg <= run_reg;
            pidx_reg <= addr_reg;
            // compare stage, working on the slot addressed in the cycle before
            if (pipe_reg)
            begin
                if (take)
                begin
                    found_reg <= 1'b1;
                    idx_reg   <= pidx_reg;
                    stamp_reg <= stamp_rd;
                    bytes_reg <= bytes_rd;
                end
                if (count_inc)
                begin
                    count_reg <= count_reg + CNT_W'(1);
                end
                if (pidx_reg == LAST_IDX)
                begin
                    done_reg <= 1'b1;
                end
            end
            if (req.go)
            begin
                run_reg   <= 1'b1;
                mode_reg  <= req.mode;
                addr_reg  <= '0;
                found_reg <= 1'b0;
                idx_reg   <= '0;
                count_reg <= '0;
            end
            else if (run_reg)
            begin
                addr_reg <= addr_reg + IDX_W'(1);
                if (addr_reg == LAST_IDX)
                begin
                    run_reg <= 1'b0;
                end
            end
        end
    end

    assign rd_addr   = addr_reg;
    assign rsp.done  = done_reg;
    assign rsp.found = found_reg;
    assign rsp.idx   = idx_reg;
    assign rsp.bytes = bytes_reg;
    assign rsp.count = count_reg;

endmodule

[tb/sv/lcb_directory_checker.sv]
// ----------------------------------------------------------------------------
// lcb_directory_checker
// tracks its own slot table, byte total and limits for the surface cache
// directory, predicts the result of every request beat and compares each
// result beat in order against the oldest prediction
// ----------------------------------------------------------------------------
module lcb_directory_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic                            busy,
    input  logic                            func,
    input  logic [lcb_pkg::KEY_PORT_W-1:0]  key,
    input  logic [lcb_pkg::SIDE_W-1:0]      width,
    input  logic [lcb_pkg::SIDE_W-1:0]      height,
    input  logic                            drawable,
    input  logic                            store_ok,
    input  logic                            done,
    input  logic [1:0]                      status,
    input  logic [lcb_pkg::SLOT_OUT_W-1:0]  slot,
    input  logic [lcb_pkg::EVICT_W-1:0]     evicted_count,
    input  logic [lcb_pkg::TOTAL_W-1:0]     bytes_in_use,
    input  logic                            cfg_we,
    input  logic [lcb_pkg::CFG_IDX_W-1:0]   cfg_addr,
    input  logic [lcb_pkg::CFG_W-1:0]       cfg_wdata,
    output int                              fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    import lcb_pkg::*;

    typedef struct packed {
        status_t                status;
        logic [SLOT_OUT_W-1:0]  slot;
        logic [EVICT_W-1:0]     evicted;
        logic [TOTAL_W-1:0]     total;
    } outcome_t;

    logic                line_valid [SLOTS];
    logic [KEY_BITS-1:0] line_key   [SLOTS];
    logic [BYTES_W-1:0]  line_bytes [SLOTS];
    logic [STAMP_W-1:0]  line_stamp [SLOTS];
    logic [TOTAL_W-1:0]  held_bytes;
    logic [STAMP_W-1:0]  use_tick;
    logic [TOTAL_W-1:0]  budget_cap;
    logic [PIX_W-1:0]    area_cap;
    logic [SIDE_W-1:0]   side_cap;

    outcome_t outcome_q [$];
    int       mismatches = 0;
    int       leftover   = 0;

    assign fail_count = mismatches + leftover;

    function automatic void drop_line(input int i);
        if (line_valid[i])
        begin
            held_bytes    = held_bytes - TOTAL_W'(line_bytes[i]);
            line_valid[i] = 1'b0;
        end
    endfunction

    // least recently stamped valid line, lowest index on ties, -1 if empty
    function automatic int oldest_line();
        int pick = -1;
        for (int i = 0; i < SLOTS; i++)
        begin
            if (line_valid[i] && (pick < 0 || line_stamp[i] < line_stamp[pick]))
                pick = i;
        end
        return pick;
    endfunction

    function automatic outcome_t resolve_request(
        input logic                 f,
        input logic [KEY_BITS-1:0]  k,
        input logic [SIDE_W-1:0]    w,
        input logic [SIDE_W-1:0]    h,
        input logic                 drw,
        input logic                 sok
    );
        outcome_t    o;
        int          at;
        int          victim;
        logic [63:0] area;
        logic [63:0] need;
        logic [7:0]  dropped;

        o       = '0;
        at      = -1;
        dropped = '0;
        area    = 64'(w) * 64'(h);
        need    = area << BPP_SHIFT;

        if (f)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                if (line_valid[i])
                    dropped++;
                line_valid[i] = 1'b0;
            end
            held_bytes = '0;
            use_tick   = '0;
            o.status   = ST_FLUSH;
        end
        else if (!drw || w == 0 || h == 0 || w > side_cap || h > side_cap ||
                 area > 64'(area_cap))
        begin
            o.status = ST_REJECT;
        end
        else
        begin
            for (int i = 0; i < SLOTS && at < 0; i++)
            begin
                if (line_valid[i] && line_key[i] == k)
                    at = i;
            end
            if (at >= 0)
            begin
                use_tick       = use_tick + 1'b1;
                line_stamp[at] = use_tick;
                o.status       = ST_HIT;
                o.slot         = SLOT_OUT_W'(at);
            end
            else if (!sok)
            begin
                o.status = ST_REJECT;
            end
            else
            begin
                // make room under the budget, oldest first
                while (64'(held_bytes) + need > 64'(budget_cap))
                begin
                    victim = oldest_line();
                    if (victim < 0)
                        break;
                    drop_line(victim);
                    dropped++;
                end
                for (int i = 0; i < SLOTS && at < 0; i++)
                begin
                    if (!line_valid[i])
                        at = i;
                end
                if (at < 0)
                begin
                    at = oldest_line();
                    drop_line(at);
                    dropped++;
                end
                line_valid[at] = 1'b1;
                line_key[at]   = k;
                line_bytes[at] = need[BYTES_W-1:0];
                held_bytes     = held_bytes + TOTAL_W'(line_bytes[at]);
                use_tick       = use_tick + 1'b1;
                line_stamp[at] = use_tick;
                o.status       = ST_INSERT;
                o.slot         = SLOT_OUT_W'(at);
            end
        end
        o.evicted = dropped;
        o.total   = held_bytes;
        return o;
    endfunction

    function automatic void check_field(input string name, input logic [63:0] want_v,
                                        input logic [63:0] got_v);
        if (got_v !== want_v)
        begin
            $error("%s: expected %0d, got %0d", name, want_v, got_v);
            mismatches++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : track
        outcome_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
                line_valid[i] = 1'b0;
            held_bytes = '0;
            use_tick   = '0;
            budget_cap = BUDGET_RST;
            area_cap   = PIXEL_RST;
            side_cap   = SIDE_RST;
            outcome_q.delete();
            leftover   = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_addr)
                    CFG_BUDGET: budget_cap = cfg_wdata[TOTAL_W-1:0];
                    CFG_PIXEL:  area_cap   = cfg_wdata[PIX_W-1:0];
                    CFG_SIDE:   side_cap   = cfg_wdata[SIDE_W-1:0];
                    default:    ;
                endcase
            end
            if (start && !busy)
                outcome_q.push_back(resolve_request(func, key[KEY_BITS-1:0], width, height,
                                                    drawable, store_ok));
            if (done)
            begin
                if (outcome_q.size() == 0)
                begin
                    $error("result beat with nothing outstanding: status %0d slot %0d",
                           status, slot);
                    mismatches++;
                end
                else
                begin
                    want = outcome_q.pop_front();
                    check_field("status", 64'(want.status), 64'(status));
                    check_field("slot", 64'(want.slot), 64'(slot));
                    check_field("evicted_count", 64'(want.evicted), 64'(evicted_count));
                    check_field("bytes_in_use", 64'(want.total), 64'(bytes_in_use));
                end
            end
            leftover = outcome_q.size();
        end
    end

endmodule

[tb/sv/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// drives the surface cache directory with a directed opening (rejects, hit,
// insert, budget eviction, oversized entries, flush) and then random request
// traffic over a reused key pool under six limit settings, with bursty start
// pacing in alternate phases; the checker predicts and compares every result
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import lcb_pkg::*;

    localparam int IDLE_LIMIT = 100000;
    localparam int PER_PHASE  = 250;
    localparam int PHASES     = 6;
    localparam int POOL       = 512;
    localparam int SIDE_MAX   = 8191;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   start     = 1'b0;
    logic                   busy;
    logic                   func      = 1'b0;
    logic [KEY_PORT_W-1:0]  key       = '0;
    logic [SIDE_W-1:0]      width     = '0;
    logic [SIDE_W-1:0]      height    = '0;
    logic                   drawable  = 1'b0;
    logic                   store_ok  = 1'b0;
    logic                   done;
    logic [1:0]             status;
    logic [SLOT_OUT_W-1:0]  slot;
    logic [EVICT_W-1:0]     evicted_count;
    logic [TOTAL_W-1:0]     bytes_in_use;
    logic                   cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_addr  = CFG_BUDGET;
    logic [CFG_W-1:0]       cfg_wdata = '0;
    int                     fail_total;

    int     sent_beats = 0;
    int     got_beats  = 0;
    int     quiet      = 0;
    int     by_status [4] = '{default: 0};
    longint evict_sum  = 0;

    logic [KEY_PORT_W-1:0]  key_pool [POOL];
    int                     pool_n     = POOL;
    int                     area_lim   = 262144;
    int                     side_lim   = 4096;
    bit                     gaps_on    = 1'b0;
    int                     burst_left = 0;

    int budgets [PHASES] = '{16777216, 1048576, 67108864, 1048576, 134217727, 67108864};
    int pixels  [PHASES] = '{262144, 262144, 1, 4096, 524287, 262144};
    int sides   [PHASES] = '{4096, 4096, 1, 64, 8191, 4096};
    int pools   [PHASES] = '{160, 24, 512, 48, 300, 96};

    lru_cache_with_byte_budget u_top (.*);

    lcb_directory_checker u_check (.*, .fail_count(fail_total));

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // beat counters and watchdog
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (start && !busy)
            sent_beats <= sent_beats + 1;
        if (done)
        begin
            got_beats         <= got_beats + 1;
            by_status[status] <= by_status[status] + 1;
            evict_sum         <= evict_sum + evicted_count;
        end
        if (quiet == IDLE_LIMIT)
        begin
            $display("[lru_cache_with_byte_budget] ERROR");
            $finish;
        end
    end

    task automatic send_request(input logic f, input logic [KEY_PORT_W-1:0] k,
                                input logic [SIDE_W-1:0] w, input logic [SIDE_W-1:0] h,
                                input logic drw, input logic sok);
        int gap;
        start    <= 1'b1;
        func     <= f;
        key      <= k;
        width    <= w;
        height   <= h;
        drawable <= drw;
        store_ok <= sok;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        if (burst_left > 0)
            burst_left--;
        else if (gaps_on)
        begin
            gap   = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 300)
                                                : $urandom_range(1, 12);
            start <= 1'b0;
            repeat (gap)
                @(posedge clk);
            burst_left = $urandom_range(0, 24);
        end
    endtask

    task automatic settle();
        start <= 1'b0;
        @(posedge clk);
        while (sent_beats != got_beats || busy)
            @(posedge clk);
        repeat (4)
            @(posedge clk);
    endtask

    task automatic program_limits(input int b, input int p, input int s);
        cfg_we    <= 1'b1;
        cfg_addr  <= CFG_BUDGET;
        cfg_wdata <= CFG_W'(b);
        @(posedge clk);
        cfg_addr  <= CFG_PIXEL;
        cfg_wdata <= CFG_W'(p);
        @(posedge clk);
        cfg_addr  <= CFG_SIDE;
        cfg_wdata <= CFG_W'(s);
        @(posedge clk);
        cfg_we    <= 1'b0;
        area_lim  = p;
        side_lim  = s;
    endtask

    task automatic random_request();
        int roll;
        int cap;
        int w;
        int h;
        roll = $urandom_range(0, 99);
        if (roll < 3)
            send_request(1'b1, {$urandom, $urandom}, SIDE_W'($urandom), SIDE_W'($urandom),
                         1'($urandom), 1'($urandom));
        else if (roll < 9)
            send_request(1'b0, {$urandom, $urandom}, SIDE_W'($urandom), SIDE_W'($urandom),
                         1'($urandom), 1'($urandom));
        else
        begin
            roll = $urandom_range(0, 99);
            cap  = (roll < 78) ? 16 : 128;
            if (cap > side_lim)
                cap = side_lim;
            w = $urandom_range(1, cap);
            h = $urandom_range(1, cap);
            if (roll >= 98)
            begin
                w = $urandom_range(0, SIDE_MAX);
                h = $urandom_range(0, SIDE_MAX);
            end
            else if (roll >= 95)
            begin
                // area near the pixel limit
                w = $urandom_range(1, side_lim);
                h = area_lim / w;
                if (h < 1)
                    h = 1;
                if (h > side_lim)
                    h = side_lim;
            end
            else if (roll >= 92)
            begin
                w = (side_lim < SIDE_MAX) ? $urandom_range(side_lim + 1, SIDE_MAX) : 0;
                if ($urandom_range(0, 1))
                begin
                    h = w;
                    w = $urandom_range(1, side_lim);
                end
            end
            send_request(1'b0, key_pool[$urandom_range(0, pool_n - 1)], SIDE_W'(w),
                         SIDE_W'(h), $urandom_range(0, 99) < 97, $urandom_range(0, 99) < 90);
        end
    endtask

    initial
    begin
        for (int i = 0; i < POOL; i++)
            key_pool[i] = {$urandom, $urandom};
        key_pool[0] = '0;
        key_pool[1] = '1;

        repeat (6)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed opening under reset limits
        send_request(1'b1, '0, '0, '0, 1'b0, 1'b0);
        send_request(1'b0, '0, 13'd1, 13'd1, 1'b0, 1'b1);
        send_request(1'b0, '0, 13'd0, 13'd1, 1'b1, 1'b1);
        send_request(1'b0, '0, 13'd1, 13'd0, 1'b1, 1'b1);
        send_request(1'b0, '0, 13'd4097, 13'd1, 1'b1, 1'b1);
        send_request(1'b0, '0, 13'd8191, 13'd8191, 1'b1, 1'b1);
        send_request(1'b0, '0, 13'd4096, 13'd64, 1'b1, 1'b1);
        send_request(1'b0, 64'd5, 13'd513, 13'd512, 1'b1, 1'b1);
        send_request(1'b0, '1, 13'd1, 13'd1, 1'b1, 1'b0);
        send_request(1'b0, '1, 13'd4096, 13'd1, 1'b1, 1'b1);
        send_request(1'b0, '0, 13'd1, 13'd1, 1'b1, 1'b0);
        send_request(1'b0, '0, 13'd1, 13'd1, 1'b0, 1'b1);
        send_request(1'b0, '0, 13'd0, 13'd1, 1'b1, 1'b1);

        // tight budget: budget evictions around oversized entries, then a flush
        settle();
        program_limits(1048576, 524287, SIDE_MAX);
        send_request(1'b0, 64'd7, 13'd8191, 13'd1, 1'b1, 1'b1);
        send_request(1'b0, 64'd8, 13'd1023, 13'd512, 1'b1, 1'b1);
        send_request(1'b0, 64'd9, 13'd1, 13'd1, 1'b1, 1'b1);
        send_request(1'b0, 64'd10, 13'd724, 13'd724, 1'b1, 1'b1);
        send_request(1'b1, '1, '1, '1, 1'b1, 1'b1);

        for (int p = 0; p < PHASES; p++)
        begin
            settle();
            program_limits(budgets[p], pixels[p], sides[p]);
            pool_n     = pools[p];
            gaps_on    = (p % 2) == 0;
            burst_left = 0;
            repeat (PER_PHASE)
                random_request();
        end

        settle();
        repeat (16)
            @(posedge clk);
        $display("%0d requests under %0d limit settings: %0d hits, %0d inserts, %0d rejects",
                 sent_beats, PHASES + 2, by_status[int'(ST_HIT)], by_status[int'(ST_INSERT)],
                 by_status[int'(ST_REJECT)]);
        $display("%0d flushes, %0d slots evicted, %0d failures",
                 by_status[int'(ST_FLUSH)], evict_sum, fail_total);
        if (fail_total == 0)
            $display("[lru_cache_with_byte_budget] OK");
        else
            $display("[lru_cache_with_byte_budget] ERROR");
        $finish;
    end

endmodule
